### rtl/core/tkpq_pkg.sv
package tkpq_pkg;

  localparam int TAG_W  = 8;
  localparam int KEY_W  = 16;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_DEQUEUE = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [KEY_W-1:0] labor;
    logic [KEY_W-1:0] recovery;
  } entry_t;

  // Output register handshake state
  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } ctrl_state_t;

  typedef struct packed {
    logic    insert;
    logic    dequeue;
    logic    clear;
    logic    load;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

### rtl/core/tkpq_ctrl.sv
module tkpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_kind,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tkpq_pkg::dp_stat_t stat,
  output tkpq_pkg::dp_cmd_t  cmd
);
  import tkpq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  // Output register may be refilled in the same cycle it drains
  assign in_stall  = (state_r == ST_HOLD) && out_stall;
  assign out_valid = (state_r == ST_HOLD);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!accept && !out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.status  = STATUS_OK;
    cmd.load    = accept;
    if (accept) begin
      case (kind_t'(in_kind))
        KIND_INSERT: begin
          if (stat.full) cmd.status = STATUS_FULL;
          else           cmd.insert = 1'b1;
        end
        KIND_DEQUEUE: begin
          if (stat.empty) cmd.status  = STATUS_EMPTY;
          else            cmd.dequeue = 1'b1;
        end
        KIND_CLEAR: cmd.clear = 1'b1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/tkpq_datapath.sv
module tkpq_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkpq_pkg::dp_cmd_t           cmd,
  input  logic [tkpq_pkg::TAG_W-1:0]  in_patient_tag,
  input  logic [tkpq_pkg::KEY_W-1:0]  in_labor_time,
  input  logic [tkpq_pkg::KEY_W-1:0]  in_recovery_time,
  output tkpq_pkg::dp_stat_t          stat,
  output logic [tkpq_pkg::STAT_W-1:0] out_status,
  output logic [tkpq_pkg::TAG_W-1:0]  out_tag,
  output logic [tkpq_pkg::KEY_W-1:0]  out_labor,
  output logic [tkpq_pkg::KEY_W-1:0]  out_recovery,
  output logic [tkpq_pkg::OCC_W-1:0]  out_occupancy
);
  import tkpq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             entry_r   [DEPTH];
  entry_t             entry_nxt [DEPTH];
  logic [DEPTH-1:0]   goes_here;
  logic [CNT_W-1:0]   count_r, count_nxt;
  entry_t             new_entry;
  logic               shift_en;

  status_t            status_r;
  entry_t             head_r;
  logic [OCC_W-1:0]   occ_r;

  assign new_entry = '{tag: in_patient_tag, labor: in_labor_time,
                       recovery: in_recovery_time};
  assign shift_en  = cmd.insert || cmd.dequeue;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      // Empty slots act as +infinity; equal keys fall after existing entries
      assign goes_here[i] = (CNT_W'(i) >= count_r) ||
                            ({new_entry.labor, new_entry.recovery} <
                             {entry_r[i].labor, entry_r[i].recovery});

      always_comb begin
        entry_nxt[i] = entry_r[i];
        if (cmd.insert) begin
          if (goes_here[i]) begin
            if (i > 0) begin
              entry_nxt[i] = goes_here[(i > 0) ? i - 1 : 0] ?
                             entry_r[(i > 0) ? i - 1 : 0] : new_entry;
            end else begin
              entry_nxt[i] = new_entry;
            end
          end
        end else if (cmd.dequeue) begin
          if (i < DEPTH - 1) entry_nxt[i] = entry_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end

      always_ff @(posedge clk) begin
        if (shift_en) entry_r[i] <= entry_nxt[i];
      end
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear)        count_nxt = '0;
    else if (cmd.insert)  count_nxt = count_r + CNT_W'(1);
    else if (cmd.dequeue) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= cmd.status;
      head_r   <= cmd.dequeue ? entry_r[0] : '0;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_status    = status_r;
  assign out_tag       = head_r.tag;
  assign out_labor     = head_r.labor;
  assign out_recovery  = head_r.recovery;
  assign out_occupancy = occ_r;

endmodule

### rtl/core/two_key_priority_queue_unit.sv
// Result: loaded into the output register at the end of the accepting cycle.
// Throughput: 1 item per cycle while in_stall is low; each insert or dequeue
//   is one shift of the sorted register row, with one key compare per slot.
// Reset (rst_n low, synchronous): queue emptied, output register invalid.
//   Slot contents are not cleared; only slots below the count are read.
module two_key_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tkpq_pkg::KIND_W-1:0] in_kind,
  input  logic [tkpq_pkg::TAG_W-1:0]  in_patient_tag,
  input  logic [tkpq_pkg::KEY_W-1:0]  in_labor_time,
  input  logic [tkpq_pkg::KEY_W-1:0]  in_recovery_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tkpq_pkg::STAT_W-1:0] out_status,
  output logic [tkpq_pkg::TAG_W-1:0]  out_tag,
  output logic [tkpq_pkg::KEY_W-1:0]  out_labor,
  output logic [tkpq_pkg::KEY_W-1:0]  out_recovery,
  output logic [tkpq_pkg::OCC_W-1:0]  out_occupancy
);
  import tkpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tkpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tkpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_patient_tag   (in_patient_tag),
    .in_labor_time    (in_labor_time),
    .in_recovery_time (in_recovery_time),
    .stat             (stat),
    .out_status       (out_status),
    .out_tag          (out_tag),
    .out_labor        (out_labor),
    .out_recovery     (out_recovery),
    .out_occupancy    (out_occupancy)
  );

endmodule
